// ----- rtl/core/snsg_pkg.sv -----
// Package for the scale note slot generator.
// Holds hash constants, register indexes, scale tables and the small
// arithmetic helpers used by the pipeline.
`default_nettype none

package snsg_pkg;

   localparam logic [31:0] GATE_MUL   = 32'd2246822519;
   localparam logic [31:0] GATE_SEED  = 32'd374761393;
   localparam logic [31:0] PITCH_MUL  = 32'd2654435761;
   localparam logic [31:0] PITCH_SEED = 32'd97;
   localparam logic [15:0] VEL_BASE   = 16'd45875;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_ROOT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OCTAVE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SUBDIV    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DENSITY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SEED      = 3'd5;

   localparam logic [3:0]  RST_KEY_ROOT = 4'd0;
   localparam logic [1:0]  RST_SCALE    = 2'd0;
   localparam logic [3:0]  RST_OCTAVE   = 4'd4;
   localparam logic [1:0]  RST_SUBDIV   = 2'd1;
   localparam logic [31:0] RST_DENSITY  = 32'd3435973836;
   localparam logic [9:0]  RST_SEED     = 10'd7;

   // one xorshift32 step
   function automatic logic [31:0] xs32(input logic [31:0] x);
      logic [31:0] a;
      logic [31:0] b;
      a = x ^ (x << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

   function automatic logic [2:0] mod6(input logic [31:0] x);
      logic [5:0] s;
      logic [3:0] f1;
      logic [2:0] f2;
      logic [1:0] m3;
      s = '0;
      for (int i = 0; i < 16; i++) begin
         s = s + 6'(x[2*i +: 2]);
      end
      f1 = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
      f2 = 3'(f1[3:2]) + 3'(f1[1:0]);
      m3 = (f2 >= 3'd3) ? 2'(f2 - 3'd3) : f2[1:0];
      return (m3[0] == x[0]) ? 3'(m3) : 3'(m3) + 3'd3;
   endfunction

   function automatic logic [2:0] mod7(input logic [31:0] x);
      logic [6:0] s;
      logic [3:0] f1;
      logic [3:0] f2;
      s = 7'(x[31:30]);
      for (int i = 0; i < 10; i++) begin
         s = s + 7'(x[3*i +: 3]);
      end
      f1 = 4'(s[6]) + 4'(s[5:3]) + 4'(s[2:0]);
      f2 = 4'(f1[3]) + 4'(f1[2:0]);
      return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
   endfunction

   function automatic logic [2:0] mod5(input logic [31:0] x);
      logic [6:0] s;
      logic [4:0] f1;
      logic [4:0] f2;
      logic [3:0] f3;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 7'(x[4*i +: 4]);
      end
      f1 = 5'(s[6:4]) + 5'(s[3:0]);
      f2 = 5'(f1[4]) + 5'(f1[3:0]);
      f3 = 4'(5'(f2[4]) + 5'(f2[3:0]));
      if (f3 >= 4'd10) begin
         f3 = f3 - 4'd10;
      end
      if (f3 >= 4'd5) begin
         f3 = f3 - 4'd5;
      end
      return f3[2:0];
   endfunction

   function automatic logic [2:0] strong_deg(input logic [2:0] i);
      case (i)
         3'd0: return 3'd0;
         3'd1: return 3'd2;
         3'd2: return 3'd4;
         3'd3: return 3'd0;
         3'd4: return 3'd4;
         3'd5: return 3'd2;
         default: return 3'd0;
      endcase
   endfunction

   function automatic logic [2:0] weak_deg(input logic [2:0] i);
      case (i)
         3'd0: return 3'd1;
         3'd1: return 3'd3;
         3'd2: return 3'd5;
         3'd3: return 3'd6;
         3'd4: return 3'd0;
         3'd5: return 3'd2;
         3'd6: return 3'd4;
         default: return 3'd0;
      endcase
   endfunction

   function automatic logic [3:0] scale_iv(input logic [1:0] mode, input logic [2:0] deg);
      case (deg)
         3'd0: return 4'd0;
         3'd1: return 4'd2;
         3'd2: return (mode == 2'd0 || mode == 2'd3) ? 4'd4 : 4'd3;
         3'd3: return 4'd5;
         3'd4: return 4'd7;
         3'd5: return (mode == 2'd1) ? 4'd8 : 4'd9;
         3'd6: return (mode == 2'd0) ? 4'd11 : 4'd10;
         default: return 4'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/scale_note_slot_generator.sv -----
// Scale note slot generator, top level.
// Four-stage pipeline from slot index to fire, pitch and velocity; uses snsg_pkg.
//
// One slot per clock enters while the result side keeps up; a result passes
// through the stages slot multiply, hash and first xorshift, second
// xorshift with digit-sum residues, and note sum with clamp into the output
// register. Each stage holds its own valid bit, so bubbles are squeezed out
// while the result side stalls.
`default_nettype none

module scale_note_slot_generator
   import snsg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,   // [31:0] slot_index
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [23:0]               rsp_tdata,   // [6:0] pitch, [22:7] velocity, [23] zero
   output logic                      rsp_tuser,   // [0] fire
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   logic [3:0]  key_root_ff;
   logic [1:0]  scale_mode_ff;
   logic [3:0]  base_octave_ff;
   logic [1:0]  subdiv_log2_ff;
   logic [31:0] density_ff;
   logic [31:0] seed_gate_ff;
   logic [16:0] seed_pitch_ff;
   logic [31:0] seed_gate_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_root_ff    <= RST_KEY_ROOT;
         scale_mode_ff  <= RST_SCALE;
         base_octave_ff <= RST_OCTAVE;
         subdiv_log2_ff <= RST_SUBDIV;
         density_ff     <= RST_DENSITY;
         seed_gate_ff   <= 32'(42'(RST_SEED) * 42'(GATE_SEED));
         seed_pitch_ff  <= 17'(17'(RST_SEED) * 17'(PITCH_SEED));
      end else if (csr_we) begin
         case (csr_index)
            REG_KEY_ROOT: key_root_ff    <= csr_wdata[3:0];
            REG_SCALE:    scale_mode_ff  <= csr_wdata[1:0];
            REG_OCTAVE:   base_octave_ff <= csr_wdata[3:0];
            REG_SUBDIV:   subdiv_log2_ff <= csr_wdata[1:0];
            REG_DENSITY:  density_ff     <= csr_wdata;
            REG_SEED: begin
               seed_gate_ff  <= seed_gate_in;
               seed_pitch_ff <= 17'(17'(csr_wdata[9:0]) * 17'(PITCH_SEED));
            end
            default: ;
         endcase
      end
   end

   assign seed_gate_in = 32'(csr_wdata[9:0]) * GATE_SEED;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4       = !s4_v_ff || rsp_tready;
   assign rdy3       = !s3_v_ff || rdy4;
   assign rdy2       = !s2_v_ff || rdy3;
   assign rdy1       = !s1_v_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (rdy1) s1_v_ff <= req_tvalid;
         if (rdy2) s2_v_ff <= s1_v_ff;
         if (rdy3) s3_v_ff <= s2_v_ff;
         if (rdy4) s4_v_ff <= s3_v_ff;
      end
   end

   // stage 1: slot multiplies and strong-slot test
   logic [31:0] gate_prod, pitch_prod;
   logic [2:0]  sub_mask;
   logic [31:0] s1_gm_ff, s1_pm_ff;
   logic        s1_strong_ff;

   assign gate_prod  = req_tdata * GATE_MUL;
   assign pitch_prod = req_tdata * PITCH_MUL;
   assign sub_mask   = 3'((4'd1 << subdiv_log2_ff) - 4'd1);

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_gm_ff     <= gate_prod;
         s1_pm_ff     <= pitch_prod;
         s1_strong_ff <= (req_tdata[2:0] & sub_mask) == 3'd0;
      end
   end

   // stage 2: seed hash, zero fix, first xorshift
   logic [31:0] gate_h, pitch_h;
   logic [31:0] s2_g1_ff, s2_p1_ff;
   logic        s2_strong_ff;

   assign gate_h  = s1_gm_ff + seed_gate_ff + 32'd1;
   assign pitch_h = s1_pm_ff + 32'(seed_pitch_ff) + 32'd1;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_g1_ff     <= xs32((gate_h == 32'd0) ? 32'd1 : gate_h);
         s2_p1_ff     <= xs32((pitch_h == 32'd0) ? 32'd1 : pitch_h);
         s2_strong_ff <= s1_strong_ff;
      end
   end

   // stage 3: gate decision, velocity draw, degree pick
   logic [31:0] vel_draw;
   logic [2:0]  deg_in;
   logic        s3_fire_ff;
   logic [15:0] s3_vel_ff;
   logic [2:0]  s3_deg_ff;
   logic [31:0] s3_p2_ff;

   assign vel_draw = xs32(s2_g1_ff);
   assign deg_in   = s2_strong_ff ? strong_deg(mod6(s2_p1_ff)) : weak_deg(mod7(s2_p1_ff));

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_fire_ff <= s2_g1_ff <= density_ff;
         s3_vel_ff  <= VEL_BASE + 16'(vel_draw[31:18]);
         s3_deg_ff  <= deg_in;
         s3_p2_ff   <= xs32(s2_p1_ff);
      end
   end

   // stage 4: octave wobble, note sum, clamp
   logic [2:0]        wob_idx;
   logic signed [4:0] oct_sum;
   logic [3:0]        oct_sat, key_mod;
   logic signed [9:0] note;
   logic [6:0]        pitch_in;
   logic              s4_fire_ff;
   logic [6:0]        s4_pitch_ff;
   logic [15:0]       s4_vel_ff;

   assign wob_idx = mod5(s3_p2_ff);
   assign oct_sat = (base_octave_ff > 4'd9) ? 4'd9 : base_octave_ff;
   assign key_mod = (key_root_ff >= 4'd12) ? key_root_ff - 4'd12 : key_root_ff;

   always_comb begin
      oct_sum = $signed({1'b0, oct_sat});
      if (wob_idx == 3'd3) begin
         oct_sum = oct_sum + 5'sd1;
      end else if (wob_idx == 3'd4) begin
         oct_sum = oct_sum - 5'sd1;
      end
      note = $signed(10'(scale_iv(scale_mode_ff, s3_deg_ff))) + $signed(10'(key_mod))
           + (10'(oct_sum) <<< 3) + (10'(oct_sum) <<< 2);
      if (note < 10'sd0) begin
         pitch_in = 7'd0;
      end else if (note > 10'sd127) begin
         pitch_in = 7'd127;
      end else begin
         pitch_in = note[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_fire_ff  <= s3_fire_ff;
         s4_pitch_ff <= s3_fire_ff ? pitch_in : 7'd0;
         s4_vel_ff   <= s3_fire_ff ? s3_vel_ff : 16'd0;
      end
   end

   assign rsp_tvalid = s4_v_ff;
   assign rsp_tuser  = s4_fire_ff;
   assign rsp_tdata  = {1'b0, s4_vel_ff, s4_pitch_ff};

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("silent slot carries nonzero pitch or velocity");

   a_vel_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[22:7] >= VEL_BASE)
      else $error("fired note velocity below floor");

   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && !rdy4 |=> s3_v_ff && $stable(s3_deg_ff) && $stable(s3_p2_ff))
      else $error("stage 3 lost its transaction during a stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- verif/snsg_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the scale note slot generator: mirrors the register writes,
// predicts fire, pitch and velocity for every accepted slot and compares results.
// Depends on snsg_pkg for port widths, register indexes and hash constants.

module snsg_checker
   import snsg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [31:0]          req_tdata,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [23:0]          rsp_tdata,
   input  wire logic                 rsp_tuser,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   output int unsigned               mismatch_count,
   output int unsigned               notes_pending
);

   typedef struct packed {
      logic        fire;
      logic [6:0]  pitch;
      logic [15:0] velocity;
   } note_type;

   localparam logic [27:0] MAJOR_STEPS  = {4'd11, 4'd9, 4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
   localparam logic [27:0] MINOR_STEPS  = {4'd10, 4'd8, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
   localparam logic [27:0] DORIAN_STEPS = {4'd10, 4'd9, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
   localparam logic [27:0] MIXO_STEPS   = {4'd10, 4'd9, 4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
   localparam logic [3:0][27:0] SCALE_STEPS =
      {MIXO_STEPS, DORIAN_STEPS, MINOR_STEPS, MAJOR_STEPS};
   localparam logic [17:0] CHORD_DEGREES = {3'd2, 3'd4, 3'd0, 3'd4, 3'd2, 3'd0};
   localparam logic [20:0] WIDE_DEGREES  = {3'd4, 3'd2, 3'd0, 3'd6, 3'd5, 3'd3, 3'd1};

   logic [3:0]  key_q;
   logic [1:0]  mode_q;
   logic [3:0]  octave_q;
   logic [1:0]  subdiv_q;
   logic [31:0] density_q;
   logic [9:0]  seed_q;

   note_type    due_notes[$];
   int unsigned fails;

   function automatic logic [31:0] xorshift32(input logic [31:0] v);
      logic [31:0] t;
      t = v ^ (v << 13);
      t = t ^ (t >> 17);
      return t ^ (t << 5);
   endfunction

   function automatic logic [31:0] slot_hash(input logic [31:0] slot, input logic [31:0] mul,
                                             input logic [31:0] smul);
      logic [31:0] h;
      h = slot * mul + {22'd0, seed_q} * smul + 32'd1;
      return (h == 32'd0) ? 32'd1 : h;
   endfunction

   function automatic note_type predict_note(input logic [31:0] slot);
      note_type    n;
      logic [31:0] gate;
      logic [31:0] draw1;
      logic [31:0] draw2;
      logic [31:0] mask;
      logic [2:0]  deg;
      int          wob;
      int          oct;
      int          note;
      n = '0;
      gate = xorshift32(slot_hash(slot, GATE_MUL, GATE_SEED));
      if (gate <= density_q) begin
         n.fire = 1'b1;
         n.velocity = VEL_BASE + 16'(xorshift32(gate) >> 18);
         draw1 = xorshift32(slot_hash(slot, PITCH_MUL, PITCH_SEED));
         draw2 = xorshift32(draw1);
         mask = (32'd1 << subdiv_q) - 32'd1;
         if ((slot & mask) == 32'd0) begin
            deg = CHORD_DEGREES[int'(draw1 % 32'd6) * 3 +: 3];
         end else begin
            deg = WIDE_DEGREES[int'(draw1 % 32'd7) * 3 +: 3];
         end
         case (draw2 % 32'd5)
            32'd3:   wob = 1;
            32'd4:   wob = -1;
            default: wob = 0;
         endcase
         oct = (octave_q > 4'd9) ? 9 : int'(octave_q);
         note = int'(SCALE_STEPS[mode_q][int'(deg) * 4 +: 4]) + int'(key_q % 4'd12)
              + (oct + wob) * 12;
         if (note < 0) note = 0;
         if (note > 127) note = 127;
         n.pitch = 7'(note);
      end
      return n;
   endfunction

   always @(posedge clock) begin
      note_type want;
      if (reset) begin
         key_q     <= RST_KEY_ROOT;
         mode_q    <= RST_SCALE;
         octave_q  <= RST_OCTAVE;
         subdiv_q  <= RST_SUBDIV;
         density_q <= RST_DENSITY;
         seed_q    <= RST_SEED;
         due_notes.delete();
         fails = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_KEY_ROOT: key_q     <= csr_wdata[3:0];
               REG_SCALE:    mode_q    <= csr_wdata[1:0];
               REG_OCTAVE:   octave_q  <= csr_wdata[3:0];
               REG_SUBDIV:   subdiv_q  <= csr_wdata[1:0];
               REG_DENSITY:  density_q <= csr_wdata;
               REG_SEED:     seed_q    <= csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            due_notes.insert(due_notes.size(), predict_note(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_notes.size() == 0) begin
               $error("note result with no slot outstanding: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               fails++;
            end else begin
               want = due_notes.pop_front();
               if (rsp_tuser !== want.fire) begin
                  $error("fire: expected %0d, got %0d", want.fire, rsp_tuser);
                  fails++;
               end
               if (rsp_tdata[6:0] !== want.pitch) begin
                  $error("pitch: expected %0d, got %0d", want.pitch, rsp_tdata[6:0]);
                  fails++;
               end
               if (rsp_tdata[22:7] !== want.velocity) begin
                  $error("velocity: expected %0d, got %0d", want.velocity, rsp_tdata[22:7]);
                  fails++;
               end
            end
         end
      end
      mismatch_count <= fails;
      notes_pending  <= due_notes.size();
   end

endmodule

// ----- verif/tb_scale_note_slot_generator.sv -----
`timescale 1ns / 100ps
// Top of the scale note slot generator bench: clock, reset, register settings and
// slot stimulus with random stalls on both channels, plus the verdict.
// Depends on snsg_pkg, scale_note_slot_generator and snsg_checker.

module tb_scale_note_slot_generator
   import snsg_pkg::*;
();

   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned RSP_HOLD_CYCLES = 64;
   localparam int unsigned ITEMS_PER_SET   = 116;
   localparam logic [CSR_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;   // [31:0] slot_index
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;         // [6:0] pitch, [22:7] velocity, [23] zero
   logic                 rsp_tuser;         // [0] fire
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_wdata  = '0;

   int unsigned mismatch_count;
   int unsigned notes_pending;
   int unsigned send_idle_pct = 37;
   int unsigned rsp_idle_pct  = 54;
   bit          rsp_hold_req  = 1'b0;
   logic [9:0]  cur_seed      = RST_SEED;
   logic [1:0]  cur_subdiv    = RST_SUBDIV;

   scale_note_slot_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   snsg_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .notes_pending  (notes_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // slot whose hash comes out zero before the zero-to-one substitution
   function automatic logic [31:0] zero_hash_slot(input logic [31:0] mul,
                                                  input logic [31:0] smul);
      logic [31:0] inv;
      inv = mul;
      repeat (5) inv = inv * (32'd2 - mul * inv);
      return (32'd0 - ({22'd0, cur_seed} * smul + 32'd1)) * inv;
   endfunction

   task automatic offer_slot(input logic [31:0] slot);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= slot;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_notes();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (notes_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [3:0] key, input logic [1:0] mode,
                                 input logic [3:0] octave, input logic [1:0] subdiv,
                                 input logic [31:0] density, input logic [9:0] seed);
      write_csr(REG_KEY_ROOT, 32'({$urandom(), key}));
      write_csr(REG_SCALE, 32'({$urandom(), mode}));
      write_csr(REG_OCTAVE, 32'({$urandom(), octave}));
      write_csr(SPARE_IDX_LO, $urandom());
      write_csr(REG_SUBDIV, 32'({$urandom(), subdiv}));
      write_csr(REG_DENSITY, density);
      write_csr(REG_SEED, 32'({$urandom(), seed}));
      write_csr(SPARE_IDX_HI, $urandom());
      csr_we     <= 1'b0;
      cur_seed   = seed;
      cur_subdiv = subdiv;
   endtask

   function automatic logic [31:0] pick_density();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return RST_DENSITY;
         3:       return 32'hFFFF_FFFF - $urandom_range(32'h0FFF_FFFF);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_slot(inout logic [31:0] run_slot);
      case ($urandom_range(11))
         0:       return $urandom_range(63);
         1:       return 32'hFFFF_FFFF - $urandom_range(63);
         2:       return $urandom() & ~((32'd1 << cur_subdiv) - 32'd1);
         3, 4, 5: begin
            run_slot = run_slot + 32'd1;
            return run_slot;
         end
         6:       return zero_hash_slot(GATE_MUL, GATE_SEED);
         7:       return zero_hash_slot(PITCH_MUL, PITCH_SEED);
         default: return $urandom();
      endcase
   endfunction

   // receiver side: random stalls, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] run_slot;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values
      offer_slot(32'd0);
      offer_slot(32'hFFFF_FFFF);
      offer_slot(32'd2);

      for (int m = 0; m < 4; m++) begin
         drain_notes();
         case (m)
            0: apply_settings(4'd0, 2'(m), 4'd0, 2'd0, 32'hFFFF_FFFF, 10'd0);
            1: apply_settings(4'd15, 2'(m), 4'd15, 2'd3, 32'hFFFF_FFFF, 10'd1023);
            2: apply_settings(4'd11, 2'(m), 4'd9, 2'd2, 32'd0, 10'd999);
            default: apply_settings(4'd12, 2'(m), 4'd10, 2'd1, RST_DENSITY, 10'd1000);
         endcase
         offer_slot(zero_hash_slot(GATE_MUL, GATE_SEED));
         offer_slot(zero_hash_slot(PITCH_MUL, PITCH_SEED));
         offer_slot(32'h8000_0000);
         offer_slot(32'd8);
         offer_slot(32'h7FFF_FFFF);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 37;
               rsp_idle_pct  = 54;
            end
            1: begin
               send_idle_pct = 54;
               rsp_idle_pct  = 37;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         for (int s = 0; s < 4; s++) begin
            drain_notes();
            apply_settings(4'($urandom_range(15)), 2'($urandom_range(3)),
                           4'($urandom_range(15)), 2'($urandom_range(3)),
                           pick_density(), 10'($urandom_range(1023)));
            run_slot = $urandom();
            if (phase == 2 && s == 0) rsp_hold_req = 1'b1;
            repeat (ITEMS_PER_SET) offer_slot(pick_slot(run_slot));
         end
      end

      drain_notes();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
